/* sv/cfd_pkg.sv */
`timescale 1ns / 1ps

package cfd_pkg;

  // fill counter and emit count: up to 64 stored bytes
  localparam int FILL_W = 7;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic REG_SYNC    = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  localparam logic [7:0] SYNC_RESET    = 8'hEE;
  localparam logic [7:0] TIMEOUT_RESET = 8'd5;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_CMD  = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_CHK  = 3'd4
  } phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } out_item_t;

  // parser -> emitter: start reading out a verified frame
  typedef struct packed {
    logic              go;
    logic [FILL_W-1:0] count;
  } emit_req_t;

endpackage

/* sv/cfd_ram.sv */
`timescale 1ns / 1ps

module cfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/cfd_parser.sv */
`timescale 1ns / 1ps

module cfd_parser #(
  parameter int MAX_PAYLOAD = 60,
  parameter int DEPTH       = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  cfd_pkg::in_item_t        in_data,
  input  logic                     in_stall,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [7:0]               cfg_wdata,
  output logic                     wr_en,
  output logic [$clog2(DEPTH)-1:0] wr_addr,
  output logic [7:0]               wr_data,
  output cfd_pkg::emit_req_t       emit_req
);

  import cfd_pkg::*;

  localparam int         AW      = $clog2(DEPTH);
  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

  phase_t            phase_r, phase_nxt;
  logic [7:0]        left_r, left_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        secs_r, secs_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]        sync_r, tmo_r;

  logic       acc;
  logic       is_byte;
  logic [7:0] b;
  logic [7:0] secs_inc;
  logic [7:0] sum_add;
  logic       room;

  assign acc      = in_valid && !in_stall;
  assign b        = in_data.rx_byte;
  assign is_byte  = (in_data.op == OP_BYTE);
  assign secs_inc = (secs_r == 8'hFF) ? secs_r : secs_r + 8'd1;
  assign sum_add  = sum_r + b;
  assign room     = (fill_r < FILL_MAX);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    sum_nxt   = sum_r;
    secs_nxt  = secs_r;
    fill_nxt  = fill_r;
    if (acc && !is_byte) begin
      unique case (phase_r)
        PH_CMD, PH_LEN, PH_DATA, PH_CHK: begin
          secs_nxt = secs_inc;
          if (secs_inc > tmo_r) begin
            phase_nxt = PH_HUNT;
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end else if (acc) begin
      unique case (phase_r)
        PH_CMD: begin
          if (room) fill_nxt = fill_r + 1'b1;
          sum_nxt   = sum_add;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if (room) fill_nxt = fill_r + 1'b1;
          sum_nxt  = sum_add;
          left_nxt = b;
          if (b > MAX_LEN) begin
            phase_nxt = PH_HUNT;
          end else if (b == 8'd0) begin
            phase_nxt = PH_CHK;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          if (room) fill_nxt = fill_r + 1'b1;
          sum_nxt  = sum_add;
          left_nxt = left_r - 8'd1;
          if (left_r == 8'd1) phase_nxt = PH_CHK;
        end
        PH_CHK: begin
          if (room) fill_nxt = fill_r + 1'b1;
          phase_nxt = PH_HUNT;
        end
        default: begin
          // hunting, and any stray code behaves the same
          phase_nxt = PH_HUNT;
          if (b == sync_r) begin
            fill_nxt  = FILL_W'(1);
            sum_nxt   = b;
            secs_nxt  = 8'd0;
            phase_nxt = PH_CMD;
          end
        end
      endcase
    end
  end

  // store writes and emit request
  always_comb begin
    wr_en          = 1'b0;
    wr_addr        = fill_r[AW-1:0];
    wr_data        = b;
    emit_req.go    = 1'b0;
    emit_req.count = fill_r + 1'b1;
    if (acc && is_byte) begin
      unique case (phase_r)
        PH_CMD, PH_LEN, PH_DATA: wr_en = room;
        PH_CHK: begin
          wr_en       = room;
          emit_req.go = (sum_r == b);
        end
        default: begin
          wr_en   = (b == sync_r);
          wr_addr = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      left_r  <= '0;
      sum_r   <= '0;
      secs_r  <= '0;
      fill_r  <= '0;
      sync_r  <= SYNC_RESET;
      tmo_r   <= TIMEOUT_RESET;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      sum_r   <= sum_nxt;
      secs_r  <= secs_nxt;
      fill_r  <= fill_nxt;
      if (cfg_we && cfg_index == REG_SYNC)    sync_r <= cfg_wdata;
      if (cfg_we && cfg_index == REG_TIMEOUT) tmo_r  <= cfg_wdata;
    end
  end

  a_emit_from_chk: assert property (@(posedge clk) disable iff (!rst_n)
    emit_req.go |-> (acc && phase_r == PH_CHK))
    else $error("emit request outside checksum phase");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("fill index beyond store depth");

  a_emit_back_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    emit_req.go |=> (phase_r == PH_HUNT))
    else $error("parser not hunting after a verified frame");

endmodule

/* sv/cfd_emitter.sv */
`timescale 1ns / 1ps

module cfd_emitter #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfd_pkg::emit_req_t       emit_req,
  output logic                     busy,
  output logic                     rd_en,
  output logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [7:0]               rd_data,
  output logic                     out_valid,
  output cfd_pkg::out_item_t       out_data,
  input  logic                     out_stall
);

  import cfd_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [FILL_W-1:0] rem_r, rem_nxt;
  logic [FILL_W-1:0] idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic              pend_last_r, pend_last_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic take;
  logic issue;

  assign take    = out_valid_r && !out_stall;
  // read only when the output register will be free as the data lands
  assign issue   = (rem_r != '0) && !pend_r && (!out_valid_r || take);
  assign rd_en   = issue;
  assign rd_addr = idx_r[AW-1:0];
  assign busy    = (rem_r != '0) || pend_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    rem_nxt       = rem_r;
    idx_nxt       = idx_r;
    pend_nxt      = issue;
    pend_last_nxt = issue && (rem_r == FILL_W'(1));
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit_req.go) begin
      rem_nxt = emit_req.count;
      idx_nxt = '0;
    end else if (issue) begin
      rem_nxt = rem_r - 1'b1;
      idx_nxt = idx_r + 1'b1;
    end
    if (pend_r) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.packet_byte = rd_data;
      out_data_nxt.last_byte   = pend_last_r;
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  a_req_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit_req.go |-> !busy)
    else $error("frame request while readout in progress");

  a_pend_lands: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> out_valid_r)
    else $error("read data not loaded into output register");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && pend_last_r |-> (rem_r == '0))
    else $error("last mark while bytes remain");

endmodule

/* sv/checksum_frame_deframer_core.sv */
`timescale 1ns / 1ps
// Checksum frame deframer.
// Input channel (in_valid / in_stall / in_data): one request per serial byte
// (op = byte) or per one-second tick (op = tick). The parser hunts for the
// sync byte, then takes command, length, payload and checksum bytes, writing
// each into a frame store RAM of MAX_PAYLOAD + 4 entries.
// Output channel (out_valid / out_stall / out_data): a frame whose checksum
// matches is read back from the RAM and sent whole, sync through checksum,
// with last_byte set on the checksum byte. Bad, overlong or timed-out
// frames produce nothing.
// After a good checksum is taken, each frame byte is read through the single
// RAM read port, registered and loaded into the output register; a new read
// is issued only once the previous read's data has landed and the output
// register is free or being taken. in_stall is held high while a frame is
// being read out. A stalled receiver simply holds the output register and
// pauses readout. Reset (rst_n, synchronous) returns the parser to hunting,
// cancels any readout and restores sync_value = 0xEE and timeout_seconds = 5.
// The RAM needs no clearing pass. Configuration writes (cfg_we / cfg_index /
// cfg_wdata) take effect at the next edge; the user must make them only
// while idle, and the block itself does not enforce this.

module checksum_frame_deframer_core #(
  parameter int MAX_PAYLOAD = 60
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cfd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cfd_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata
);

  import cfd_pkg::*;

  localparam int DEPTH = MAX_PAYLOAD + 4;
  localparam int AW    = $clog2(DEPTH);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  emit_req_t     emit_req;
  logic          busy;

  assign in_stall = busy;

  cfd_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .DEPTH       (DEPTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .emit_req  (emit_req)
  );

  cfd_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cfd_emitter #(
    .DEPTH (DEPTH)
  ) u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit_req  (emit_req),
    .busy      (busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

/* sim/cfd_checker.sv */
`timescale 1ns / 1ps

module cfd_checker
  import cfd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 60
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_item_t  out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  output int         fail_count,
  output int         pending,
  output int         req_count,
  output int         byte_count,
  output int         frame_count
);

  localparam int STORE_DEPTH = MAX_PAYLOAD + 4;
  localparam int LOG_CAP     = 50;

  logic [7:0]        sync_reg;
  logic [7:0]        timeout_reg;
  phase_t            phase;
  logic [7:0]        payload_left;
  logic [7:0]        running_sum;
  logic [7:0]        elapsed_s;
  logic [FILL_W-1:0] fill_idx;
  logic [7:0]        frame_buf [64];
  out_item_t         frame_bytes_q [$];

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want_v);
    if (fail_count < LOG_CAP)
      $display("%0t ns: %s: got %02h, want %02h", $time, what, got, want_v);
    fail_count++;
  endtask

  task automatic keep_byte(logic [7:0] b);
    if (fill_idx < STORE_DEPTH && fill_idx < 64) begin
      frame_buf[fill_idx] = b;
      fill_idx = fill_idx + 1'b1;
    end
  endtask

  // advance the parser by one request; a good checksum queues the whole frame
  task automatic take_request(in_item_t req);
    logic [7:0] b;
    out_item_t  r;
    b = req.rx_byte;
    if (req.op == OP_TICK) begin
      if (phase != PH_HUNT) begin
        if (elapsed_s != 8'hFF)
          elapsed_s = elapsed_s + 1'b1;
        if (elapsed_s > timeout_reg)
          phase = PH_HUNT;
      end
    end else begin
      case (phase)
        PH_HUNT: begin
          if (b == sync_reg) begin
            fill_idx = '0;
            keep_byte(b);
            running_sum = b;
            elapsed_s = '0;
            phase = PH_CMD;
          end
        end
        PH_CMD: begin
          keep_byte(b);
          running_sum = running_sum + b;
          phase = PH_LEN;
        end
        PH_LEN: begin
          keep_byte(b);
          running_sum = running_sum + b;
          payload_left = b;
          if (b > MAX_PAYLOAD)
            phase = PH_HUNT;
          else if (b == 8'd0)
            phase = PH_CHK;
          else
            phase = PH_DATA;
        end
        PH_DATA: begin
          keep_byte(b);
          running_sum = running_sum + b;
          payload_left = payload_left - 1'b1;
          if (payload_left == 8'd0)
            phase = PH_CHK;
        end
        default: begin
          keep_byte(b);
          if (running_sum == b) begin
            for (int k = 0; k < fill_idx && k < 64; k++) begin
              r.packet_byte = frame_buf[k];
              r.last_byte   = (k + 1 == fill_idx);
              frame_bytes_q.push_back(r);
            end
          end
          phase = PH_HUNT;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      sync_reg     = SYNC_RESET;
      timeout_reg  = TIMEOUT_RESET;
      phase        = PH_HUNT;
      payload_left = '0;
      running_sum  = '0;
      elapsed_s    = '0;
      fill_idx     = '0;
      frame_bytes_q.delete();
      fail_count   = 0;
      req_count    = 0;
      byte_count   = 0;
      frame_count  = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SYNC)
          sync_reg = cfg_wdata;
        else
          timeout_reg = cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        req_count++;
        take_request(in_data);
      end
      if (out_valid && !out_stall) begin
        byte_count++;
        if (frame_bytes_q.size() == 0) begin
          report_mismatch("frame byte with none expected", out_data.packet_byte, 8'h00);
        end else begin
          want = frame_bytes_q.pop_front();
          if (out_data.packet_byte !== want.packet_byte)
            report_mismatch("packet_byte", out_data.packet_byte, want.packet_byte);
          if (out_data.last_byte !== want.last_byte)
            report_mismatch("last_byte", {7'd0, out_data.last_byte}, {7'd0, want.last_byte});
          if (want.last_byte)
            frame_count++;
        end
      end
    end
    pending = frame_bytes_q.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import cfd_pkg::*;

  localparam int MAX_PAYLOAD = 60;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;
  localparam int CHUNK       = 90;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_wdata;

  int fail_count, pending, req_count, byte_count, frame_count;

  int         idle_cycles = 0;
  int         in_idle_pct = 0;
  int         out_idle_pct = 0;
  int         sent_reqs = 0;
  bit         hold_off_now = 1'b0;
  logic [7:0] cur_sync;
  logic [7:0] cur_timeout;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  checksum_frame_deframer_core #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  cfd_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .req_count  (req_count),
    .byte_count (byte_count),
    .frame_count(frame_count)
  );

  function automatic in_item_t byte_req(logic [7:0] b);
    in_item_t r;
    r.op      = OP_BYTE;
    r.rx_byte = b;
    return r;
  endfunction

  // rx_byte is don't-care on a tick, so randomise it
  function automatic in_item_t tick_req();
    in_item_t r;
    r.op      = OP_TICK;
    r.rx_byte = 8'($urandom);
    return r;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 25;
      default: return 60;
    endcase
  endfunction

  task automatic push_req(in_item_t req);
    int gap;
    gap = 0;
    if ($urandom_range(99) < in_idle_pct)
      gap = ($urandom_range(9) == 0) ? $urandom_range(60, 15) : $urandom_range(3, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sent_reqs++;
  endtask

  // sync, command, length, payload, checksum; ticks land after sync and before the last byte
  task automatic send_frame(int len, int ticks, bit bad_sum, bit all_sync);
    in_item_t   frame_q [$];
    logic [7:0] sum;
    logic [7:0] b;
    int         pos;
    sum = cur_sync;
    frame_q.push_back(byte_req(cur_sync));
    b = 8'($urandom);
    sum = sum + b;
    frame_q.push_back(byte_req(b));
    sum = sum + 8'(len);
    frame_q.push_back(byte_req(8'(len)));
    if (len <= MAX_PAYLOAD) begin
      for (int i = 0; i < len; i++) begin
        b = (all_sync || $urandom_range(7) == 0) ? cur_sync : 8'($urandom);
        sum = sum + b;
        frame_q.push_back(byte_req(b));
      end
      frame_q.push_back(byte_req(bad_sum ? sum ^ 8'($urandom_range(255, 1)) : sum));
    end
    repeat (ticks) begin
      pos = $urandom_range(frame_q.size() - 1, 1);
      frame_q.insert(pos, tick_req());
    end
    foreach (frame_q[i]) push_req(frame_q[i]);
  endtask

  task automatic random_traffic(int quota);
    int stop_at, kind, len, safe_ticks;
    stop_at = sent_reqs + quota;
    send_frame(MAX_PAYLOAD, 0, 1'b0, 1'b0);
    while (sent_reqs < stop_at) begin
      if ($urandom_range(15) == 0) begin
        in_idle_pct  = pick_idle_pct();
        out_idle_pct = pick_idle_pct();
      end
      kind = $urandom_range(99);
      len  = ($urandom_range(19) == 0) ? $urandom_range(MAX_PAYLOAD, 30) : $urandom_range(8);
      safe_ticks = (cur_timeout < 10) ? cur_timeout : 10;
      safe_ticks = ($urandom_range(3) == 0) ? $urandom_range(safe_ticks) : 0;
      if (kind < 70)
        send_frame(len, safe_ticks, 1'b0, 1'b0);
      else if (kind < 78)
        send_frame(len, safe_ticks, 1'b1, 1'b0);
      else if (kind < 84)
        send_frame($urandom_range(255, MAX_PAYLOAD + 1), 0, 1'b0, 1'b0);
      else if (kind < 90 && cur_timeout < 8)
        send_frame(len, cur_timeout + 1 + $urandom_range(2), 1'b0, 1'b0);
      else
        repeat ($urandom_range(4, 1))
          push_req(($urandom_range(3) == 0) ? tick_req() : byte_req(8'($urandom)));
    end
  endtask

  // drop valid, wait for the last frame to drain, then let the parser go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apply_settings(logic [7:0] sync_v, logic [7:0] timeout_v);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SYNC;
    cfg_wdata <= sync_v;
    @(posedge clk);
    cfg_index <= REG_TIMEOUT;
    cfg_wdata <= timeout_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_sync    = sync_v;
    cur_timeout = timeout_v;
  endtask

  initial begin : receiver
    int span;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_now) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_now = 1'b0;
      end else if ($urandom_range(99) < out_idle_pct) begin
        span = ($urandom_range(9) == 0) ? $urandom_range(50, 15) : $urandom_range(3, 1);
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
      $display("checksum_frame_deframer_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = REG_SYNC;
    cfg_wdata   = '0;
    cur_sync    = SYNC_RESET;
    cur_timeout = TIMEOUT_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tick and stray byte, empty frames good and bad,
    // overlong length, a sync byte as the payload with ticks right at the limit
    in_idle_pct  = 30;
    out_idle_pct = 30;
    push_req(tick_req());
    push_req(byte_req(8'h00));
    send_frame(0, 0, 1'b0, 1'b0);
    send_frame(0, 0, 1'b1, 1'b0);
    send_frame(MAX_PAYLOAD + 1, 0, 1'b0, 1'b0);
    send_frame(1, TIMEOUT_RESET, 1'b0, 1'b1);
    settle();

    // receiver holds off while a full frame and two shorter ones arrive back to back
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_off_now = 1'b1;
    send_frame(MAX_PAYLOAD, 0, 1'b0, 1'b0);
    send_frame(4, 0, 1'b0, 1'b0);
    send_frame(0, 0, 1'b0, 1'b0);
    settle();

    random_traffic(CHUNK);
    settle();
    apply_settings(8'h00, 8'h00);
    random_traffic(CHUNK);
    settle();
    apply_settings(8'hFF, 8'hFF);
    random_traffic(CHUNK);
    settle();
    apply_settings(8'($urandom), 8'($urandom_range(20, 1)));
    random_traffic(CHUNK);
    settle();
    repeat (20) @(posedge clk);

    $display("sent %0d requests over reset, 00/00, FF/FF and random sync/timeout settings",
             req_count);
    $display("checked %0d frame bytes in %0d good frames, %0d mismatches",
             byte_count, frame_count, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("checksum_frame_deframer_core regression: pass");
    else
      $display("checksum_frame_deframer_core regression: fail");
    $finish;
  end

endmodule
